// ----- sv/rde_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rde_pkg
// Shared types, constants and helpers for the radix digit emitter.
// ============================================================================
package rde_pkg;

    // Width of the converted value and depth of the digit store
    localparam int VALUE_BITS  = 32;
    localparam int DIGIT_DEPTH = VALUE_BITS;
    localparam int IDX_BITS    = $clog2(DIGIT_DEPTH);
    localparam int COUNT_BITS  = IDX_BITS + 1;

    // Digit and character widths
    localparam int DIGIT_BITS = 6;
    localparam int CHAR_BITS  = 7;

    // Radix limits and reset value
    localparam logic [DIGIT_BITS-1:0] RADIX_MIN   = 6'd2;
    localparam logic [DIGIT_BITS-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_BITS-1:0] RADIX_RESET = 6'd10;

    // ASCII mapping constants
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO     = 7'd48;
    localparam logic [CHAR_BITS-1:0] LETTER_OFFSET = 7'd55;
    localparam logic [DIGIT_BITS-1:0] DECIMAL_TOP  = 6'd10;

    // Register map (index of the radix register)
    localparam logic REG_RADIX = 1'b0;

    // Sequencer phases
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DIVIDE,
        PH_READ,
        PH_PUT
    } phase_t;

    // Divider status as seen by the sequencer
    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [DIGIT_BITS-1:0] remainder;
    } div_result_t;

    // Saturate the programmed radix into the range two to thirty-six
    function automatic logic [DIGIT_BITS-1:0] clamp_radix(input logic [DIGIT_BITS-1:0] r);
        logic [DIGIT_BITS-1:0] res;
        if (r < RADIX_MIN)
            res = RADIX_MIN;
        else if (r > RADIX_MAX)
            res = RADIX_MAX;
        else
            res = r;
        return res;
    endfunction

    // Map a digit value to its ASCII character
    function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] res;
        if (d < DECIMAL_TOP)
            res = CHAR_ZERO + {1'b0, d};
        else
            res = {1'b0, d} + LETTER_OFFSET;
        return res;
    endfunction

endpackage

// ----- sv/rde_divider.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rde_divider
// Restoring shift-subtract divider: one quotient bit per cycle, shifting
// through every bit of the value to divide it by the radix.
// ============================================================================
module rde_divider
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [rde_pkg::VALUE_BITS-1:0]      dividend,
    input  logic [rde_pkg::DIGIT_BITS-1:0]      divisor,
    output rde_pkg::div_result_t                result
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [rde_pkg::IDX_BITS-1:0]        step_reg;
    logic [rde_pkg::VALUE_BITS-1:0]      quot_reg;
    logic [rde_pkg::DIGIT_BITS-1:0]      acc_reg;

    logic [rde_pkg::DIGIT_BITS:0]        trial;
    logic [rde_pkg::DIGIT_BITS:0]        diff;
    logic                                fits;
    logic [rde_pkg::DIGIT_BITS-1:0]      acc_next;
    logic [rde_pkg::VALUE_BITS-1:0]      quot_next;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb
    begin
        trial     = {acc_reg, quot_reg[rde_pkg::VALUE_BITS-1]};
        diff      = trial - {1'b0, divisor};
        fits      = (trial >= {1'b0, divisor});
        acc_next  = fits ? diff[rde_pkg::DIGIT_BITS-1:0] : trial[rde_pkg::DIGIT_BITS-1:0];
        quot_next = {quot_reg[rde_pkg::VALUE_BITS-2:0], fits};
    end

    // Control: step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == rde_pkg::IDX_BITS'(rde_pkg::VALUE_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load the dividend, then shift one bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_next;
            acc_reg  <= acc_next;
        end
    end

    assign result.done      = done_reg;
    assign result.quotient  = quot_reg;
    assign result.remainder = acc_reg;

endmodule

// ----- sv/radix_digit_emitter.sv -----
`timescale 1ns / 1ps
// ============================================================================
// radix_digit_emitter
// Converts an unsigned value to ASCII digits of a programmable radix,
// most significant first, with the final character marked by tlast.
// ============================================================================
// Each digit comes from the shared shift-subtract divider (one quotient bit a
// cycle); once the quotient reaches zero, each character is read from the digit
// store and then loaded into the output beat, waiting while a held beat is untaken.
// A new value is taken only after the last character has been loaded; s_tready
// is high only while the sequencer is idle.
// Reset: asynchronous, active low; clears sequencer and output beat, radix ten.
// ============================================================================
module radix_digit_emitter
(
    input  logic        clk,
    input  logic        rst_n,

    // Input stream: tdata = value[31:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,

    // Output stream: tdata = digit_char[6:0], zero[7]; tlast = last_digit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    rde_pkg::phase_t                         state_reg, state_next;
    logic [rde_pkg::DIGIT_BITS-1:0]          radix_reg;
    logic [rde_pkg::COUNT_BITS-1:0]          count_reg, count_next;
    logic [rde_pkg::IDX_BITS-1:0]            idx_reg, idx_next;
    logic [rde_pkg::DIGIT_BITS-1:0]          rd_data_reg;
    logic [rde_pkg::DIGIT_BITS-1:0]          digit_store [rde_pkg::DIGIT_DEPTH];
    logic                                    out_valid_reg, out_valid_next;
    logic [rde_pkg::CHAR_BITS-1:0]           out_char_reg, out_char_next;
    logic                                    out_last_reg, out_last_next;

    logic                                    in_beat;
    logic                                    cfg_write;
    logic                                    slot_free;
    logic                                    div_start;
    logic [rde_pkg::VALUE_BITS-1:0]          div_dividend;
    logic                                    store_we;
    logic                                    count_full;
    rde_pkg::div_result_t                    div_res;

    assign in_beat    = s_tvalid && s_tready;
    assign slot_free  = !out_valid_reg || m_tready;
    assign count_full = (count_reg == rde_pkg::COUNT_BITS'(rde_pkg::DIGIT_DEPTH));
    assign cfg_write  = psel && penable && pwrite && (paddr[2] == rde_pkg::REG_RADIX);

    // Configuration register and read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= rde_pkg::RADIX_RESET;
        else if (cfg_write)
            radix_reg <= pwdata[rde_pkg::DIGIT_BITS-1:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == rde_pkg::REG_RADIX) ?
                    {{(32-rde_pkg::DIGIT_BITS){1'b0}}, radix_reg} : 32'd0;

    // Shared divider
    rde_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (rde_pkg::clamp_radix(radix_reg)),
        .result   (div_res)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rde_pkg::PH_IDLE:
                if (in_beat)
                    state_next = rde_pkg::PH_DIVIDE;
            rde_pkg::PH_DIVIDE:
                if (div_res.done && (div_res.quotient == '0))
                    state_next = rde_pkg::PH_READ;
            rde_pkg::PH_READ:
                state_next = rde_pkg::PH_PUT;
            rde_pkg::PH_PUT:
                if (slot_free)
                    state_next = (idx_reg == '0) ? rde_pkg::PH_IDLE : rde_pkg::PH_READ;
            default:
                state_next = rde_pkg::PH_IDLE;
        endcase
    end

    // Sequencer outputs and datapath next values
    always_comb
    begin
        s_tready       = 1'b0;
        div_start      = 1'b0;
        div_dividend   = div_res.quotient;
        store_we       = 1'b0;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            rde_pkg::PH_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    div_start    = 1'b1;
                    div_dividend = s_tdata;
                    count_next   = '0;
                end
            end
            rde_pkg::PH_DIVIDE:
                if (div_res.done)
                begin
                    // Keep the digit, divide the quotient again unless it is zero
                    if (!count_full)
                    begin
                        store_we   = 1'b1;
                        count_next = count_reg + 1'b1;
                        idx_next   = count_reg[rde_pkg::IDX_BITS-1:0];
                    end
                    else
                        idx_next = rde_pkg::IDX_BITS'(rde_pkg::DIGIT_DEPTH - 1);
                    if (div_res.quotient != '0)
                        div_start = 1'b1;
                end
            rde_pkg::PH_READ:
            begin
            end
            rde_pkg::PH_PUT:
                if (slot_free)
                begin
                    // Load the next character beat, most significant first
                    out_valid_next = 1'b1;
                    out_char_next  = rde_pkg::digit_to_ascii(rd_data_reg);
                    out_last_next  = (idx_reg == '0);
                    if (idx_reg != '0)
                        idx_next = idx_reg - 1'b1;
                end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rde_pkg::PH_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    // Digit store: write on divider completion, registered read
    always_ff @(posedge clk)
    begin
        if (store_we)
            digit_store[count_reg[rde_pkg::IDX_BITS-1:0]] <= div_res.remainder;
        if (state_reg == rde_pkg::PH_READ)
            rd_data_reg <= digit_store[idx_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_last_reg;

endmodule
